// ----- src/two_type_bracket_unrank_core_defines.svh -----
// assertion helpers shared by the bracket unrank rtl
// both expect clk and rst_n in the scope where they are used
`ifndef TWO_TYPE_BRACKET_UNRANK_CORE_DEFINES_SVH
`define TWO_TYPE_BRACKET_UNRANK_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TTBU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TTBU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ttbu_pkg.sv -----
`default_nettype none

package ttbu_pkg;

    // fixed field widths
    localparam int CNT_W   = 64;
    localparam int RANK_W  = 63;
    localparam int PAIRS_W = 5;

    localparam logic [PAIRS_W-1:0] PAIRS_RESET = 5'd1;

    // bracket codes, ordered as the sequences are ranked
    typedef enum logic [1:0] {
        BR_OPEN_ROUND   = 2'd0,
        BR_CLOSE_ROUND  = 2'd1,
        BR_OPEN_SQUARE  = 2'd2,
        BR_CLOSE_SQUARE = 2'd3
    } bracket_t;

    // unrank sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_ISSUE,
        S_COUNT,
        S_PICK
    } ttbu_state_t;

    // table build sequencer
    typedef enum logic [1:0] {
        TB_INIT,
        TB_FILL,
        TB_DONE
    } ttbu_build_state_t;

    // status from the count table to the sequencer
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] total;
    } ttbu_table_stat_t;

endpackage

`default_nettype wire

// ----- src/ttbu_rank_if.sv -----
`default_nettype none

interface ttbu_rank_if
    import ttbu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

`default_nettype wire

// ----- src/ttbu_bracket_if.sv -----
`default_nettype none

interface ttbu_bracket_if
    import ttbu_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] bracket;
    logic       last;
    logic       out_of_range;

    modport source (output valid, output bracket, output last, output out_of_range,
                    input ready);
    modport sink   (input valid, input bracket, input last, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

// ----- src/two_type_bracket_unrank_core.sv -----
// two-kind bracket sequence unrank core
// req carries a 63-bit zero-based rank; rsp returns the matching balanced
// sequence over ( ) [ ], one bracket per word, last set on the final one.
// a rank at or past the number of sequences returns one word with bracket
// '(' and both last and out_of_range set.
// pairs is set through cfg_wr_en / cfg_wr_data; zero counts as one and
// values above MAX_PAIRS saturate. each write rebuilds the count table.
// after reset and after every write the table is rebuilt, and req.ready
// stays low meanwhile. each bracket passes through three steps: issue of
// two count-memory reads, shift and threshold sums, then the compare and
// pick. a new rank is taken only after the last bracket, or the error
// word, of the previous one has been loaded into the output register.
// one output register decouples rsp; if rsp.ready is low the sequencer
// holds at the pick step, and a new rank may be accepted while a final
// word still waits.
`default_nettype none

`include "two_type_bracket_unrank_core_defines.svh"

module two_type_bracket_unrank_core
    import ttbu_pkg::*;
#(
    parameter int MAX_PAIRS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [PAIRS_W-1:0] cfg_wr_data,
    ttbu_rank_if.sink          req,
    ttbu_bracket_if.source     rsp
);

    localparam int PW = $clog2(MAX_PAIRS + 1);
    localparam int RW = $clog2(2 * MAX_PAIRS + 1);
    localparam int SW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    ttbu_state_t       state_reg, state_next;
    logic [PAIRS_W-1:0] pairs_reg;
    logic [PW-1:0]     p_eff;
    logic [RW-1:0]     len_m1;
    ttbu_table_stat_t  tstat;

    logic [RANK_W-1:0] rem_reg, rem_next;
    logic [PW-1:0]     depth_reg, depth_next;
    logic [RW-1:0]     rest_reg, rest_next;
    logic [MAX_PAIRS-1:0] stack_reg, stack_next;

    logic              v1_reg, v1_next, v2_reg, v2_next;
    logic [PW-1:0]     sh1_reg, sh1_next, sh2_reg, sh2_next;
    logic [CNT_W-1:0]  t1_reg, t1_next;
    logic [CNT_W:0]    t2_reg, t2_next;
    logic [CNT_W+1:0]  t3_reg, t3_next;

    logic              out_valid_reg, out_valid_next;
    bracket_t          out_bracket_reg, out_bracket_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;

    logic              req_ready;
    logic              slot_free;
    logic [PW-1:0]     depth_m1;
    logic              v1, v2;
    logic [PW-1:0]     h1, h2;
    logic [RW-1:0]     diff1, diff2;
    logic [CNT_W-1:0]  rd1, rd2;
    logic [CNT_W-1:0]  c1, c2;
    logic [CNT_W+1:0]  rem_w;
    logic              lt1, lt2, lt3;
    bracket_t          br_pick;
    logic [CNT_W+1:0]  sub_pick;
    logic [CNT_W+1:0]  rem_left;

    // effective pair count
    always_comb
    begin
        if (pairs_reg == '0)
        begin
            p_eff = PW'(1);
        end
        else if (pairs_reg > PAIRS_W'(MAX_PAIRS))
        begin
            p_eff = PW'(MAX_PAIRS);
        end
        else
        begin
            p_eff = pairs_reg[PW-1:0];
        end
    end

    assign len_m1 = RW'({p_eff, 1'b0}) - 1'b1;

    // count table
    ttbu_table #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_wr_en),
        .p         (p_eff),
        .rd_rest_a (rest_reg),
        .rd_h_a    (h1),
        .rd_rest_b (rest_reg),
        .rd_h_b    (h2),
        .rd_data_a (rd1),
        .rd_data_b (rd2),
        .stat      (tstat)
    );

    // candidate heights and whether they can still return to zero
    assign depth_m1 = depth_reg - 1'b1;
    assign v1 = (depth_reg < p_eff) && ((RW'(depth_reg) + 1'b1) <= rest_reg);
    assign v2 = (depth_reg != '0) && !stack_reg[depth_m1[SW-1:0]] &&
                (RW'(depth_m1) <= rest_reg);
    assign h1 = v1 ? depth_reg + 1'b1 : '0;
    assign h2 = v2 ? depth_m1 : '0;
    assign diff1 = rest_reg - RW'(h1);
    assign diff2 = rest_reg - RW'(h2);

    // completion counts scaled by the free pairs
    assign c1 = v1_reg ? (rd1 << sh1_reg) : '0;
    assign c2 = v2_reg ? (rd2 << sh2_reg) : '0;

    // pick against the cumulative thresholds
    assign rem_w = (CNT_W+2)'(rem_reg);
    assign lt1   = rem_w < (CNT_W+2)'(t1_reg);
    assign lt2   = rem_w < (CNT_W+2)'(t2_reg);
    assign lt3   = rem_w < t3_reg;

    always_comb
    begin
        if (lt1)
        begin
            br_pick  = BR_OPEN_ROUND;
            sub_pick = '0;
        end
        else if (lt2)
        begin
            br_pick  = BR_CLOSE_ROUND;
            sub_pick = (CNT_W+2)'(t1_reg);
        end
        else if (lt3)
        begin
            br_pick  = BR_OPEN_SQUARE;
            sub_pick = (CNT_W+2)'(t2_reg);
        end
        else
        begin
            br_pick  = BR_CLOSE_SQUARE;
            sub_pick = t3_reg;
        end
    end

    assign rem_left  = rem_w - sub_pick;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == S_IDLE) && !tstat.busy;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        depth_next       = depth_reg;
        rest_next        = rest_reg;
        stack_next       = stack_reg;
        v1_next          = v1_reg;
        v2_next          = v2_reg;
        sh1_next         = sh1_reg;
        sh2_next         = sh2_reg;
        t1_next          = t1_reg;
        t2_next          = t2_reg;
        t3_next          = t3_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_bracket_next = out_bracket_reg;
        out_last_next    = out_last_reg;
        out_err_next     = out_err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req_ready)
                begin
                    rem_next   = req.rank;
                    depth_next = '0;
                    rest_next  = len_m1;
                    if ({1'b0, req.rank} >= tstat.total)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_bracket_next = BR_OPEN_ROUND;
                    out_last_next    = 1'b1;
                    out_err_next     = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_ISSUE:
            begin
                v1_next    = v1;
                v2_next    = v2;
                sh1_next   = PW'(diff1 >> 1);
                sh2_next   = PW'(diff2 >> 1);
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                t1_next    = c1;
                t2_next    = (CNT_W+1)'(c1) + (CNT_W+1)'(c2);
                t3_next    = (CNT_W+2)'({c1, 1'b0}) + (CNT_W+2)'(c2);
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (slot_free)
                begin
                    rem_next = rem_left[RANK_W-1:0];
                    if (br_pick == BR_OPEN_ROUND || br_pick == BR_OPEN_SQUARE)
                    begin
                        if (depth_reg < PW'(MAX_PAIRS))
                        begin
                            stack_next[depth_reg[SW-1:0]] = (br_pick == BR_OPEN_SQUARE);
                        end
                        depth_next = depth_reg + 1'b1;
                    end
                    else if (depth_reg != '0)
                    begin
                        depth_next = depth_m1;
                    end
                    out_valid_next   = 1'b1;
                    out_bracket_next = br_pick;
                    out_last_next    = (rest_reg == '0);
                    out_err_next     = 1'b0;
                    if (rest_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rest_next  = rest_reg - 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pairs_reg     <= PAIRS_RESET;
            depth_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
            if (cfg_wr_en)
            begin
                pairs_reg <= cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        rest_reg        <= rest_next;
        stack_reg       <= stack_next;
        v1_reg          <= v1_next;
        v2_reg          <= v2_next;
        sh1_reg         <= sh1_next;
        sh2_reg         <= sh2_next;
        t1_reg          <= t1_next;
        t2_reg          <= t2_next;
        t3_reg          <= t3_next;
        out_bracket_reg <= out_bracket_next;
        out_last_reg    <= out_last_next;
        out_err_reg     <= out_err_next;
    end

    assign req.ready        = req_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.bracket      = out_bracket_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.out_of_range = out_err_reg;

    // checks
    `TTBU_ASSERT_NOW(a_err_word_shape, rsp.valid && rsp.out_of_range, rsp.last && rsp.bracket == 2'(BR_OPEN_ROUND), "error word must be a final open-round word")
    `TTBU_ASSERT_NOW(a_depth_bound, state_reg != S_IDLE, depth_reg <= p_eff, "nesting depth above pair count")
    `TTBU_ASSERT_NOW(a_accept_table_ready, req.valid && req.ready, !tstat.busy, "rank taken while table is building")
    `TTBU_ASSERT_NOW(a_pick_no_underflow, state_reg == S_PICK, rem_w >= sub_pick, "picked threshold exceeds remaining rank")

endmodule

`default_nettype wire

// ----- src/ttbu_table.sv -----
`default_nettype none

module ttbu_table
    import ttbu_pkg::*;
#(
    parameter int MAX_PAIRS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    restart,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]          p,
    input  logic [$clog2(2*MAX_PAIRS+1)-1:0]        rd_rest_a,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]          rd_h_a,
    input  logic [$clog2(2*MAX_PAIRS+1)-1:0]        rd_rest_b,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]          rd_h_b,
    output logic [CNT_W-1:0]                        rd_data_a,
    output logic [CNT_W-1:0]                        rd_data_b,
    output ttbu_table_stat_t                        stat
);

    localparam int PW    = $clog2(MAX_PAIRS + 1);
    localparam int RW    = $clog2(2 * MAX_PAIRS + 1);
    localparam int COLS  = MAX_PAIRS + 1;
    localparam int DEPTH = (2 * MAX_PAIRS + 1) * COLS;
    localparam int AW    = $clog2(DEPTH);

    ttbu_build_state_t state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next_idx;
    logic [PW-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]  cur_reg [COLS];
    logic [CNT_W-1:0]  row_next [COLS];
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  mem [DEPTH];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              row_end;
    logic              last_row;

    // row-major cell address: rest selects the row, height the column
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [PW-1:0] h);
        cell_addr = AW'(r) * AW'(COLS) + AW'(h);
    endfunction

    // next row of walk counts: arrive from one step below or one step above
    for (genvar j = 0; j < COLS; j++) begin : g_next
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        if (j > 0) begin : g_lo
            assign lo = cur_reg[j-1];
        end else begin : g_lo_zero
            assign lo = '0;
        end
        if (j < MAX_PAIRS) begin : g_hi
            assign hi = (PW'(j) < p) ? cur_reg[j+1] : '0;
        end else begin : g_hi_zero
            assign hi = '0;
        end
        assign row_next[j] = (PW'(j) <= p) ? lo + hi : '0;
    end

    assign row_end  = (col_reg == p);
    assign last_row = (row_reg == RW'({p, 1'b0}));
    assign wr_en    = (state_reg == TB_FILL);
    assign wr_addr  = cell_addr(row_reg, col_reg);

    // build sequencer
    always_comb
    begin
        state_next   = state_reg;
        row_next_idx = row_reg;
        col_next     = col_reg;
        case (state_reg)
            TB_INIT:
            begin
                row_next_idx = '0;
                col_next     = '0;
                state_next   = TB_FILL;
            end
            TB_FILL:
            begin
                if (row_end)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        state_next = TB_DONE;
                    end
                    else
                    begin
                        row_next_idx = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            TB_DONE:
            begin
                state_next = TB_DONE;
            end
            default:
            begin
                state_next = TB_INIT;
            end
        endcase
        if (restart)
        begin
            state_next = TB_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TB_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // counters, working row and total
    always_ff @(posedge clk)
    begin
        row_reg <= row_next_idx;
        col_reg <= col_next;
        if (state_reg == TB_INIT)
        begin
            for (int k = 0; k < COLS; k++)
            begin
                cur_reg[k] <= (k == 0) ? CNT_W'(1) : '0;
            end
        end
        else if (state_reg == TB_FILL && row_end)
        begin
            if (last_row)
            begin
                total_reg <= cur_reg[0] << p;
            end
            else
            begin
                cur_reg <= row_next;
            end
        end
    end

    // count memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cur_reg[col_reg];
        end
        rd_data_a <= mem[cell_addr(rd_rest_a, rd_h_a)];
        rd_data_b <= mem[cell_addr(rd_rest_b, rd_h_b)];
    end

    assign stat.busy  = (state_reg != TB_DONE);
    assign stat.total = total_reg;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import ttbu_pkg::*;
();

    localparam int PAIRS_CAP   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_PER_SETTING = 33;

    // one expected output word
    typedef struct packed {
        bracket_t bracket;
        logic     last;
        logic     out_of_range;
    } bracket_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [PAIRS_W-1:0] cfg_wr_data;

    ttbu_rank_if    rank_ch ();
    ttbu_bracket_if bracket_ch ();

    two_type_bracket_unrank_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (rank_ch),
        .rsp         (bracket_ch)
    );

    // predictor state: walk counts bounded by the effective pair count
    logic [63:0] walk_count [0:2*PAIRS_CAP][0:PAIRS_CAP];
    int          pairs_eff;

    bracket_word_t   brackets_due[$];
    logic [RANK_W-1:0] ranks_pending[$];

    int  errors;
    int  ranks_queued;
    int  ranks_taken;
    int  cycles;
    bit  rank_took;
    bit  word_took;
    bit  no_idle;
    int  send_gap;
    int  recv_stall;
    int  hold_req;
    int  hold_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // walk counts for the effective pair count
    function automatic void build_walks(logic [PAIRS_W-1:0] v);
        int i;
        int j;
        if (v == 0)
            pairs_eff = 1;
        else if (v > PAIRS_CAP)
            pairs_eff = PAIRS_CAP;
        else
            pairs_eff = int'(v);
        for (i = 0; i <= 2 * PAIRS_CAP; i++)
            for (j = 0; j <= PAIRS_CAP; j++)
                walk_count[i][j] = '0;
        walk_count[0][0] = 64'd1;
        for (i = 0; i < 2 * pairs_eff; i++)
            for (j = 0; j <= pairs_eff; j++)
            begin
                if (j > 0)
                    walk_count[i+1][j-1] += walk_count[i][j];
                if (j < pairs_eff)
                    walk_count[i+1][j+1] += walk_count[i][j];
            end
    endfunction

    // sequences that finish from height h with rest positions left
    function automatic logic [63:0] tail_count(int rest, int h);
        if (h > pairs_eff || h > rest || rest > 2 * pairs_eff)
            return '0;
        return walk_count[rest][h] << ((rest - h) / 2);
    endfunction

    function automatic logic [63:0] sequence_total();
        return tail_count(2 * pairs_eff, 0);
    endfunction

    // unrank one rank into the expected bracket words
    function automatic void unrank_into_due(logic [RANK_W-1:0] rank);
        logic [63:0]   rem;
        logic [63:0]   c;
        logic          sq_open [0:PAIRS_CAP-1];
        int            lvl;
        int            len;
        int            pos;
        int            rest;
        int            k;
        bracket_t      br;
        bracket_word_t w;
        len = 2 * pairs_eff;
        rem = {1'b0, rank};
        lvl = 0;
        for (k = 0; k < PAIRS_CAP; k++)
            sq_open[k] = 1'b0;
        // rank past the end gives a single error word
        if (rem >= sequence_total())
        begin
            w.bracket      = BR_OPEN_ROUND;
            w.last         = 1'b1;
            w.out_of_range = 1'b1;
            brackets_due = {brackets_due, w};
            return;
        end
        for (pos = 0; pos < len; pos++)
        begin
            rest = len - 1 - pos;
            c = (lvl < pairs_eff) ? tail_count(rest, lvl + 1) : '0;
            if (rem < c)
                br = BR_OPEN_ROUND;
            else
            begin
                rem -= c;
                c = '0;
                if (lvl > 0 && lvl <= PAIRS_CAP && !sq_open[lvl-1])
                    c = tail_count(rest, lvl - 1);
                if (rem < c)
                    br = BR_CLOSE_ROUND;
                else
                begin
                    rem -= c;
                    c = (lvl < pairs_eff) ? tail_count(rest, lvl + 1) : '0;
                    if (rem < c)
                        br = BR_OPEN_SQUARE;
                    else
                    begin
                        rem -= c;
                        br = BR_CLOSE_SQUARE;
                    end
                end
            end
            // track open kinds
            if (br == BR_OPEN_ROUND || br == BR_OPEN_SQUARE)
            begin
                if (lvl < PAIRS_CAP)
                    sq_open[lvl] = (br == BR_OPEN_SQUARE);
                lvl++;
            end
            else if (lvl > 0)
                lvl--;
            w.bracket      = br;
            w.last         = (pos + 1 == len);
            w.out_of_range = 1'b0;
            brackets_due = {brackets_due, w};
        end
    endfunction

    // handshake sampling, prediction and word check
    always @(posedge clk)
    begin
        bracket_word_t exp_w;
        if (rst_n)
        begin
            if (rank_ch.valid && rank_ch.ready)
            begin
                unrank_into_due(rank_ch.rank);
                ranks_taken++;
                rank_took = 1'b1;
            end
            if (bracket_ch.valid && bracket_ch.ready)
            begin
                word_took = 1'b1;
                if (brackets_due.size() == 0)
                begin
                    $error("word with nothing expected: bracket %0d last %0b oor %0b",
                           bracket_ch.bracket, bracket_ch.last, bracket_ch.out_of_range);
                    errors++;
                end
                else
                begin
                    exp_w = brackets_due.pop_front();
                    if (bracket_ch.bracket !== exp_w.bracket)
                    begin
                        $error("bracket: expected %0d, got %0d",
                               exp_w.bracket, bracket_ch.bracket);
                        errors++;
                    end
                    if (bracket_ch.last !== exp_w.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_w.last, bracket_ch.last);
                        errors++;
                    end
                    if (bracket_ch.out_of_range !== exp_w.out_of_range)
                    begin
                        $error("out_of_range: expected %0b, got %0b",
                               exp_w.out_of_range, bracket_ch.out_of_range);
                        errors++;
                    end
                end
            end
        end
    end

    // rank driver
    always @(negedge clk)
    begin
        if (rst_n && !(rank_ch.valid && !rank_took))
        begin
            if (rank_took)
            begin
                rank_took = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (send_gap == 0 && ranks_pending.size() > 0)
            begin
                rank_ch.rank  <= ranks_pending.pop_front();
                rank_ch.valid <= 1'b1;
            end
            else
            begin
                if (send_gap > 0)
                    send_gap--;
                rank_ch.valid <= 1'b0;
            end
        end
    end

    // bracket receiver with per-word stalls and one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_took)
            begin
                word_took = 1'b0;
                recv_stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                bracket_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                bracket_ch.ready <= 1'b0;
            end
            else
                bracket_ch.ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic queue_rank(logic [RANK_W-1:0] r);
        ranks_pending = {ranks_pending, r};
        ranks_queued++;
    endtask

    // block idle: every rank taken and every word seen
    task automatic wait_drained();
        while (ranks_taken != ranks_queued || brackets_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pairs(logic [PAIRS_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        build_walks(v);
    endtask

    initial
    begin
        logic [PAIRS_W-1:0] settings [0:11];
        logic [63:0]        r;
        logic [63:0]        total;
        int                 s;
        int                 n;
        int                 taken_mark;
        settings = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd2, 5'd3,
                     5'd5, 5'd8, 5'd11, 5'd15, 5'd4, 5'd1};
        errors       = 0;
        ranks_queued = 0;
        ranks_taken  = 0;
        cycles       = 0;
        rank_took    = 1'b0;
        word_took    = 1'b0;
        no_idle      = 1'b0;
        send_gap     = 0;
        recv_stall   = 0;
        hold_req     = 0;
        hold_left    = 0;
        taken_mark   = 0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        rank_ch.valid    = 1'b0;
        rank_ch.rank     = '0;
        bracket_ch.ready = 1'b0;
        build_walks(PAIRS_RESET);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset pair count: both sequences, then ranks past the end
        queue_rank(63'd0);
        queue_rank(63'd1);
        queue_rank(63'd2);
        queue_rank({RANK_W{1'b1}});
        queue_rank({1'b1, {(RANK_W-1){1'b0}}});
        wait_drained();

        for (s = 0; s < 12; s++)
        begin
            write_pairs(settings[s]);
            no_idle = (s % 4 == 3);
            total = sequence_total();
            taken_mark = ranks_taken;
            // first settings get the boundary ranks
            if (s < 3)
            begin
                queue_rank(63'd0);
                queue_rank(total[RANK_W-1:0] - 1'b1);
                queue_rank(total[RANK_W-1:0]);
            end
            for (n = 0; n < RAND_PER_SETTING; n++)
            begin
                r = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 85)
                    queue_rank(RANK_W'(r % total));
                else
                    case ($urandom_range(0, 2))
                        0: queue_rank(r[RANK_W-1:0]);
                        1: queue_rank(RANK_W'(total[RANK_W-1:0] + $urandom_range(0, 3)));
                        default: queue_rank({RANK_W{1'b1}});
                    endcase
            end
            // receiver holds off once the table is up while ranks keep coming
            if (s == 1)
            begin
                while (ranks_taken == taken_mark)
                    @(posedge clk);
                hold_req = 400;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/ttbu_pkg.sv
src/ttbu_rank_if.sv
src/ttbu_bracket_if.sv
src/ttbu_table.sv
src/two_type_bracket_unrank_core.sv
dv/tb_top.sv
